[sv/kmsm_pkg.sv]
// ----------------------------------------------------------------------------
// kmsm_pkg
// Shared types and constants of the key matrix scanner.
// ----------------------------------------------------------------------------
package kmsm_pkg;

  localparam int RowW     = 4;
  localparam int ColBitsW = 3;
  localparam int NoteW    = 7;
  localparam int StatusW  = 8;
  localparam int ChanW    = 4;

  localparam logic [StatusW-1:0] NoteOnBase  = 8'h90;
  localparam logic [StatusW-1:0] NoteOffBase = 8'h80;

  localparam logic [ChanW-1:0] ChannelRst = 4'd0;
  localparam logic [NoteW-1:0] BaseKeyRst = 7'd36;
  localparam logic [NoteW-1:0] TopKeyRst  = 7'd62;

  typedef enum logic [1:0] {
    RegChannel = 2'd0,
    RegBaseKey = 2'd1,
    RegTopKey  = 2'd2
  } reg_addr_e;

  // what one column lane found for the current row
  typedef struct packed {
    logic             change;
    logic             on;
    logic [NoteW-1:0] note;
  } lane_res_t;

endpackage

[sv/kmsm_lane.sv]
// ----------------------------------------------------------------------------
// kmsm_lane
// One column lane: note number, range check and pressed flags of its column.
// ----------------------------------------------------------------------------
module kmsm_lane #(
  parameter int ROWS = 12,
  parameter int COL  = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [kmsm_pkg::RowW-1:0]     row_i,
  input  logic                          level_i,
  input  logic [kmsm_pkg::NoteW-1:0]    base_key_i,
  input  logic [kmsm_pkg::NoteW-1:0]    top_key_i,
  output kmsm_pkg::lane_res_t           result_o
);

  localparam int RowIdxW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [7:0] ColOffset = 8'(ROWS * COL);

  logic               flag_q [ROWS];
  logic [RowIdxW-1:0] idx;
  logic               row_ok;
  logic               in_range;
  logic [7:0]         note_full;
  logic               change;

  assign idx       = row_i[RowIdxW-1:0];
  assign row_ok    = {1'b0, row_i} < 5'(ROWS);
  assign note_full = {1'b0, base_key_i} + {4'b0, row_i} + ColOffset;
  assign in_range  = note_full <= {1'b0, top_key_i};
  assign change    = row_ok && in_range && (level_i != flag_q[idx]);

  always_comb begin
    result_o.change = change;
    result_o.on     = level_i;
    result_o.note   = note_full[kmsm_pkg::NoteW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ROWS; r++) begin
        flag_q[r] <= 1'b0;
      end
    end else if (accept_i && change) begin
      flag_q[idx] <= level_i;
    end
  end

endmodule

[sv/kmsm_merge.sv]
// ----------------------------------------------------------------------------
// kmsm_merge
// Holds the lane results of one row and sends its messages in column order.
// ----------------------------------------------------------------------------
module kmsm_merge #(
  parameter int COLUMNS = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  kmsm_pkg::lane_res_t           lane_res_i [COLUMNS],
  input  logic [kmsm_pkg::ChanW-1:0]    channel_i,
  output logic                          in_ready_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [kmsm_pkg::StatusW-1:0]  status_byte_o,
  output logic [kmsm_pkg::NoteW-1:0]    note_o,
  output logic                          last_o
);

  localparam int ColIdxW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  logic [COLUMNS-1:0]         mask_q, mask_d;
  kmsm_pkg::lane_res_t        pend_q [COLUMNS];
  logic [COLUMNS-1:0]         new_mask;
  logic [COLUMNS-1:0]         remaining;
  logic [ColIdxW-1:0]         sel;
  logic                       load;
  logic                       last;

  logic                          out_valid_q, out_valid_d;
  logic [kmsm_pkg::StatusW-1:0]  status_q;
  logic [kmsm_pkg::NoteW-1:0]    note_q;
  logic                          last_q;

  always_comb begin
    for (int c = 0; c < COLUMNS; c++) begin
      new_mask[c] = lane_res_i[c].change;
    end
  end

  // lowest pending column goes first
  always_comb begin
    sel = '0;
    for (int c = COLUMNS - 1; c >= 0; c--) begin
      if (mask_q[c]) begin
        sel = ColIdxW'(c);
      end
    end
  end

  assign remaining  = mask_q & ~(COLUMNS'(1) << sel);
  assign last       = remaining == '0;
  assign load       = (mask_q != '0) && (!out_valid_q || out_ready_i);
  assign in_ready_o = (mask_q == '0) || (load && last);

  always_comb begin
    mask_d = mask_q;
    if (accept_i) begin
      mask_d = new_mask;
    end else if (load) begin
      mask_d = remaining;
    end
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      for (int c = 0; c < COLUMNS; c++) begin
        pend_q[c] <= lane_res_i[c];
      end
    end
    if (load) begin
      status_q <= (pend_q[sel].on ? kmsm_pkg::NoteOnBase : kmsm_pkg::NoteOffBase)
                  + {4'b0, channel_i};
      note_q   <= pend_q[sel].note;
      last_q   <= last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_byte_o = status_q;
  assign note_o        = note_q;
  assign last_o        = last_q;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i |-> (mask_q == '0) || (load && last))
    else $error("row taken while messages still pending");

  a_hold_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mask_q != '0) && !load && !accept_i |=> mask_q == $past(mask_q))
    else $error("pending columns changed while output stalled");

  a_one_per_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && !accept_i |=> $countones(mask_q) + 1 == $past($countones(mask_q)))
    else $error("message send did not retire exactly one column");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_q)
    else $error("loaded message not presented");
`endif

endmodule

[sv/key_matrix_scan_to_midi_notes.sv]
// ----------------------------------------------------------------------------
// key_matrix_scan_to_midi_notes
// Turns scanned key matrix rows into MIDI note on and note off messages.
// ----------------------------------------------------------------------------
// Each item is one scanned row. All COLUMNS keys of the row are checked at
// once by column lanes, which also update the pressed flags on acceptance.
// The changes found are held in a one-row pending slot and sent one message
// per cycle, unless out_ready_i stalls the output, through the output
// register, lowest column first, the last one marked. A new row is accepted
// only when the slot is empty or its last message is loaded into the single
// output message register, from which each message is presented.
// Pressed flags are flip-flops cleared by reset; no clearing pass is needed.
module key_matrix_scan_to_midi_notes #(
  parameter int ROWS    = 12,
  parameter int COLUMNS = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [kmsm_pkg::RowW-1:0]     row_i,
  input  logic [kmsm_pkg::ColBitsW-1:0] column_bits_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [kmsm_pkg::StatusW-1:0]  status_byte_o,
  output logic [kmsm_pkg::NoteW-1:0]    note_o,
  output logic                          last_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic [kmsm_pkg::ChanW-1:0] channel_q;
  logic [kmsm_pkg::NoteW-1:0] base_key_q;
  logic [kmsm_pkg::NoteW-1:0] top_key_q;
  logic                       cfg_wr;
  logic                       accept;

  kmsm_pkg::lane_res_t lane_res [COLUMNS];

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channel_q  <= kmsm_pkg::ChannelRst;
      base_key_q <= kmsm_pkg::BaseKeyRst;
      top_key_q  <= kmsm_pkg::TopKeyRst;
    end else if (cfg_wr) begin
      case (kmsm_pkg::reg_addr_e'(paddr[3:2]))
        kmsm_pkg::RegChannel: channel_q  <= pwdata[kmsm_pkg::ChanW-1:0];
        kmsm_pkg::RegBaseKey: base_key_q <= pwdata[kmsm_pkg::NoteW-1:0];
        kmsm_pkg::RegTopKey:  top_key_q  <= pwdata[kmsm_pkg::NoteW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (kmsm_pkg::reg_addr_e'(paddr[3:2]))
      kmsm_pkg::RegChannel: prdata = {28'b0, channel_q};
      kmsm_pkg::RegBaseKey: prdata = {25'b0, base_key_q};
      kmsm_pkg::RegTopKey:  prdata = {25'b0, top_key_q};
      default:              prdata = '0;
    endcase
  end

  assign accept = in_valid_i && in_ready_o;

  for (genvar c = 0; c < COLUMNS; c++) begin : g_lane
    logic level;
    // columns past the port width read as released
    if (c < kmsm_pkg::ColBitsW) begin : g_bit
      assign level = column_bits_i[c];
    end else begin : g_zero
      assign level = 1'b0;
    end

    kmsm_lane #(
      .ROWS (ROWS),
      .COL  (c)
    ) u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .accept_i   (accept),
      .row_i      (row_i),
      .level_i    (level),
      .base_key_i (base_key_q),
      .top_key_i  (top_key_q),
      .result_o   (lane_res[c])
    );
  end

  kmsm_merge #(
    .COLUMNS (COLUMNS)
  ) u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .lane_res_i    (lane_res),
    .channel_i     (channel_q),
    .in_ready_o    (in_ready_o),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_byte_o (status_byte_o),
    .note_o        (note_o),
    .last_o        (last_o)
  );

endmodule
